[rtl/ttc_pkg.sv]
package ttc_pkg;

   localparam int unsigned AmountWidth = 64;
   localparam int unsigned RateWidth   = 32;
   localparam int unsigned ExpWidth    = 5;
   localparam int unsigned CsrIdxWidth = 8;

   localparam logic [RateWidth-1:0] GigaRate     = 32'd1000000000;
   localparam logic [RateWidth-1:0] BaseFreqInit = 32'd1000000;
   localparam logic [ExpWidth-1:0]  ExpInit      = 5'd0;

   localparam logic [CsrIdxWidth-1:0] CsrBaseFreq = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CsrPrescale = 8'd1;

   localparam logic FuncTicksToNs = 1'b0;

   typedef struct packed {
      logic                   valid;
      logic                   zr;
      logic                   ovf;
      logic [RateWidth-1:0]   src;
      logic [RateWidth-1:0]   tgt;
      logic [AmountWidth-1:0] whole;
   } side_type;

   typedef struct packed {
      side_type               side;
      logic [RateWidth-1:0]   rem;
      logic [AmountWidth-1:0] dq;
   } cell_type;

endpackage

[rtl/tick_time_converter.sv]
// Pipeline from accepted request to response: 64-cell quotient chain, two
// multiply/add stages, 64-cell remainder-scaling chain, output register.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and rsp_stall is high.
// Reset: synchronous, active high; clears all stage valids and restores
// base_frequency to 1000000 and prescale_exponent to 0.
module tick_time_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [ttc_pkg::AmountWidth-1:0] req_amount,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ttc_pkg::AmountWidth-1:0] rsp_converted,
   output logic                            rsp_overflow,
   output logic                            rsp_zero_rate,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ttc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [63:0]                     csr_data
);

   logic [ttc_pkg::RateWidth-1:0] base_ff;
   logic [ttc_pkg::ExpWidth-1:0]  exp_ff;
   logic en;
   logic [ttc_pkg::RateWidth-1:0] rate;
   ttc_pkg::side_type s0;

   ttc_pkg::side_type d1_side;
   logic [ttc_pkg::AmountWidth-1:0] d1_quot;
   logic [ttc_pkg::RateWidth-1:0]   d1_rem;

   ttc_pkg::side_type m1_ff;
   logic [63:0] plo_ff, phi_ff, rp_ff;
   ttc_pkg::side_type m2_ff;
   ttc_pkg::side_type m2_in;
   logic [63:0] num2_ff;
   logic [96:0] full;

   ttc_pkg::side_type d2_side;
   logic [ttc_pkg::AmountWidth-1:0] d2_quot;
   logic [ttc_pkg::RateWidth-1:0]   d2_rem;
   logic [64:0] sum;

   logic        out_vld_ff;
   logic [63:0] out_conv_ff;
   logic        out_ovf_ff;
   logic        out_zr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= ttc_pkg::BaseFreqInit;
         exp_ff  <= ttc_pkg::ExpInit;
      end else if (csr_valid) begin
         if (csr_index == ttc_pkg::CsrBaseFreq) begin
            base_ff <= csr_data[ttc_pkg::RateWidth-1:0];
         end
         if (csr_index == ttc_pkg::CsrPrescale) begin
            exp_ff <= csr_data[ttc_pkg::ExpWidth-1:0];
         end
      end
   end

   assign en        = !out_vld_ff || !rsp_stall;
   assign req_stall = !en;

   always_comb begin
      rate     = base_ff >> exp_ff;
      s0.valid = req_valid;
      s0.zr    = (rate == '0);
      s0.ovf   = 1'b0;
      s0.whole = '0;
      if (s0.zr) begin
         s0.src = 32'd1;
         s0.tgt = 32'd1;
      end else if (req_func == ttc_pkg::FuncTicksToNs) begin
         s0.src = rate;
         s0.tgt = ttc_pkg::GigaRate;
      end else begin
         s0.src = ttc_pkg::GigaRate;
         s0.tgt = rate;
      end
   end

   ttc_divider u_div_whole (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .side_in  (s0),
      .num      (req_amount),
      .side_out (d1_side),
      .quot     (d1_quot),
      .rem      (d1_rem)
   );

   // split 64x32 product into two 32x32 halves
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff <= '0;
      end else if (en) begin
         m1_ff <= d1_side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= {32'd0, d1_quot[31:0]} * {32'd0, d1_side.tgt};
         phi_ff <= {32'd0, d1_quot[63:32]} * {32'd0, d1_side.tgt};
         rp_ff  <= {32'd0, d1_rem} * {32'd0, d1_side.tgt};
      end
   end

   assign full = {1'b0, phi_ff, 32'd0} + {33'd0, plo_ff};

   always_comb begin
      m2_in       = m1_ff;
      m2_in.whole = full[63:0];
      m2_in.ovf   = |full[96:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_ff <= '0;
      end else if (en) begin
         m2_ff <= m2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num2_ff <= rp_ff;
      end
   end

   ttc_divider u_div_part (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .side_in  (m2_ff),
      .num      (num2_ff),
      .side_out (d2_side),
      .quot     (d2_quot),
      .rem      (d2_rem)
   );

   assign sum = {1'b0, d2_side.whole} + {1'b0, d2_quot};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= d2_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_zr_ff   <= d2_side.zr;
         out_conv_ff <= d2_side.zr ? '0 : sum[63:0];
         out_ovf_ff  <= !d2_side.zr && (d2_side.ovf || sum[64]) && (d2_rem == d2_rem);
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_converted = out_conv_ff;
   assign rsp_overflow  = out_ovf_ff;
   assign rsp_zero_rate = out_zr_ff;

`ifndef SYNTHESIS
   a_zero_rate_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_rate |-> rsp_converted == '0 && !rsp_overflow)
      else $error("zero_rate response carries data");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

[rtl/ttc_div_cell.sv]
module ttc_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ttc_pkg::cell_type din,
   output ttc_pkg::cell_type dout
);

   ttc_pkg::cell_type cell_ff;
   ttc_pkg::cell_type cell_in;
   logic [ttc_pkg::RateWidth:0] trial;
   logic [ttc_pkg::RateWidth:0] diff;
   logic qbit;

   always_comb begin
      trial = {din.rem, din.dq[ttc_pkg::AmountWidth-1]};
      diff  = trial - {1'b0, din.side.src};
      qbit  = (trial >= {1'b0, din.side.src});
      cell_in      = din;
      cell_in.rem  = qbit ? diff[ttc_pkg::RateWidth-1:0] : trial[ttc_pkg::RateWidth-1:0];
      cell_in.dq   = {din.dq[ttc_pkg::AmountWidth-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dout = cell_ff;

endmodule

[rtl/ttc_divider.sv]
module ttc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  ttc_pkg::side_type                 side_in,
   input  logic [ttc_pkg::AmountWidth-1:0]   num,
   output ttc_pkg::side_type                 side_out,
   output logic [ttc_pkg::AmountWidth-1:0]   quot,
   output logic [ttc_pkg::RateWidth-1:0]     rem
);

   ttc_pkg::cell_type chain [0:ttc_pkg::AmountWidth];

   assign chain[0] = {side_in, {ttc_pkg::RateWidth{1'b0}}, num};

   for (genvar i = 0; i < ttc_pkg::AmountWidth; i++) begin : g_cell
      ttc_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .din   (chain[i]),
         .dout  (chain[i+1])
      );
   end

   assign side_out = chain[ttc_pkg::AmountWidth].side;
   assign quot     = chain[ttc_pkg::AmountWidth].dq;
   assign rem      = chain[ttc_pkg::AmountWidth].rem;

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic FuncNsToTicks = ~ttc_pkg::FuncTicksToNs;
   localparam logic [ttc_pkg::CsrIdxWidth-1:0] CsrUnlisted = 8'hA5;
   localparam int WatchdogLimit = 6000;
   localparam int DrainCycles = 150;

   typedef struct {
      logic [ttc_pkg::AmountWidth-1:0] converted;
      logic                            overflow;
      logic                            zero_rate;
   } conv_type;

   typedef struct {
      logic                            func;
      logic [ttc_pkg::AmountWidth-1:0] amount;
   } req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = 1'b0;
   logic [ttc_pkg::AmountWidth-1:0] req_amount = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ttc_pkg::AmountWidth-1:0] rsp_converted;
   logic rsp_overflow;
   logic rsp_zero_rate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ttc_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   tick_time_converter i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [ttc_pkg::RateWidth-1:0] base_freq = ttc_pkg::BaseFreqInit;
   logic [ttc_pkg::ExpWidth-1:0]  prescale = ttc_pkg::ExpInit;

   req_type  pending_reqs[$];
   conv_type expected_convs[$];
   int    send_idle_pct = 0;
   int    stall_pct = 0;
   bit    hold_sender = 1'b0;
   int    errors = 0;
   int    n_sent = 0;
   int    n_checked = 0;
   int    n_ovf = 0;
   int    n_zero = 0;
   int    quiet_cycles = 0;

   function automatic conv_type scale_amount(logic func,
                                             logic [ttc_pkg::AmountWidth-1:0] amt);
      logic [ttc_pkg::RateWidth-1:0] rate;
      logic [63:0] src, tgt, quot, rem, part;
      logic [127:0] whole;
      logic [64:0] sum;
      conv_type r;
      rate = base_freq >> prescale;
      r.converted = '0;
      r.overflow = 1'b0;
      r.zero_rate = 1'b0;
      if (rate == '0) begin
         r.zero_rate = 1'b1;
         return r;
      end
      if (func == ttc_pkg::FuncTicksToNs) begin
         src = {32'd0, rate};
         tgt = {32'd0, ttc_pkg::GigaRate};
      end else begin
         src = {32'd0, ttc_pkg::GigaRate};
         tgt = {32'd0, rate};
      end
      quot = amt / src;
      rem = amt % src;
      whole = {64'd0, quot} * {64'd0, tgt};
      part = (rem * tgt) / src;
      sum = {1'b0, whole[63:0]} + {1'b0, part};
      r.converted = sum[63:0];
      r.overflow = (whole[127:64] != '0) || sum[64];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_convs.push_back(scale_amount(req_func, req_amount));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (!hold_sender && pending_reqs.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_type it;
               it = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_func <= it.func;
               req_amount <= it.amount;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_convs.size() == 0) begin
               $error("unexpected response transaction: converted=%h", rsp_converted);
               errors++;
            end else begin
               conv_type e;
               e = expected_convs.pop_front();
               n_checked++;
               if (e.overflow) n_ovf++;
               if (e.zero_rate) n_zero++;
               if (rsp_converted !== e.converted) begin
                  $error("converted: expected %h, actual %h", e.converted, rsp_converted);
                  errors++;
               end
               if (rsp_overflow !== e.overflow) begin
                  $error("overflow: expected %b, actual %b", e.overflow, rsp_overflow);
                  errors++;
               end
               if (rsp_zero_rate !== e.zero_rate) begin
                  $error("zero_rate: expected %b, actual %b", e.zero_rate, rsp_zero_rate);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic csr_write(logic [ttc_pkg::CsrIdxWidth-1:0] idx, logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ttc_pkg::CsrBaseFreq) base_freq = data[ttc_pkg::RateWidth-1:0];
      else if (idx == ttc_pkg::CsrPrescale) prescale = data[ttc_pkg::ExpWidth-1:0];
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_convs.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_req(logic func, logic [ttc_pkg::AmountWidth-1:0] amt);
      req_type it;
      it.func = func;
      it.amount = amt;
      pending_reqs.push_back(it);
   endtask

   function automatic logic [ttc_pkg::AmountWidth-1:0] rand_amount();
      logic [ttc_pkg::AmountWidth-1:0] a;
      a = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return a;
         1: return a >> $urandom_range(63);
         2: return a >> $urandom_range(40, 63);
         default: return ((a >> 40) * {32'd0, ttc_pkg::GigaRate}) +
                         {62'd0, 2'($urandom_range(3))};
      endcase
   endfunction

   task automatic directed_set();
      add_req(ttc_pkg::FuncTicksToNs, '0);
      add_req(FuncNsToTicks, '0);
      add_req(ttc_pkg::FuncTicksToNs, 64'd1);
      add_req(FuncNsToTicks, 64'd1);
      add_req(ttc_pkg::FuncTicksToNs, '1);
      add_req(FuncNsToTicks, '1);
      add_req(FuncNsToTicks, 64'd999999999);
      add_req(FuncNsToTicks, 64'd1000000000);
      add_req(ttc_pkg::FuncTicksToNs, 64'h8000_0000_0000_0000);
      add_req(ttc_pkg::FuncTicksToNs, 64'd18446744073);
      add_req(ttc_pkg::FuncTicksToNs, 64'd18446744074);
   endtask

   initial begin
      int mode;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults, then extreme rates, wide shifts, ignored index, zero rate
      directed_set();
      wait_idle();
      csr_write(ttc_pkg::CsrBaseFreq, 64'hFFFF_FFFF_0000_0001);
      csr_write(ttc_pkg::CsrPrescale, 64'd0);
      directed_set();
      wait_idle();
      csr_write(ttc_pkg::CsrBaseFreq, 64'hFFFF_FFFF);
      csr_write(ttc_pkg::CsrPrescale, 64'hFFFF_FFFF_FFFF_FFFF);
      directed_set();
      wait_idle();
      csr_write(ttc_pkg::CsrPrescale, 64'd30);
      csr_write(CsrUnlisted, 64'd0);
      add_req(ttc_pkg::FuncTicksToNs, '1);
      add_req(FuncNsToTicks, '1);
      wait_idle();
      csr_write(ttc_pkg::CsrBaseFreq, 64'd0);
      add_req(ttc_pkg::FuncTicksToNs, 64'd12345);
      add_req(FuncNsToTicks, '1);
      wait_idle();
      csr_write(ttc_pkg::CsrBaseFreq, 64'd1);
      csr_write(ttc_pkg::CsrPrescale, 64'd1);
      add_req(ttc_pkg::FuncTicksToNs, 64'd7);
      add_req(FuncNsToTicks, 64'd7);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         mode = ph % 4;
         send_idle_pct = (mode == 1) ? 84 : (mode == 3) ? 35 : 0;
         stall_pct = (mode == 2) ? 84 : (mode == 3) ? 35 : 0;
         case ($urandom_range(3))
            0: csr_write(ttc_pkg::CsrBaseFreq, {$urandom, $urandom});
            1: csr_write(ttc_pkg::CsrBaseFreq, 64'($urandom_range(1, 2000)));
            2: csr_write(ttc_pkg::CsrBaseFreq, 64'($urandom_range(0, 3)));
            default: csr_write(ttc_pkg::CsrBaseFreq, 64'd1000000000);
         endcase
         csr_write(ttc_pkg::CsrPrescale, 64'($urandom_range(0, 31)));
         for (int n = 0; n < 114; n++) begin
            add_req(1'($urandom_range(1)), rand_amount());
            if (n == 55 && ph == 2) begin
               while (pending_reqs.size() > 20)
                  @(posedge clock);
               hold_sender = 1'b1;
               while (req_valid || expected_convs.size() > 0)
                  @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         wait_idle();
      end

      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d and checked %0d transactions in both directions over many rates,",
               n_sent, n_checked);
      $display("  %0d with overflow and %0d with zero rate.", n_ovf, n_zero);
      if (errors == 0 && expected_convs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ttc_pkg.sv
rtl/ttc_div_cell.sv
rtl/ttc_divider.sv
rtl/tick_time_converter.sv
tb/testbench.sv
